FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with async reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

FILE: src/crcbam_pkg.sv
// ----------------------------------------------------------------------------
// crcbam_pkg
// Types, codes and bit-level helpers for the multi-width augmented CRC.
// ----------------------------------------------------------------------------
package crcbam_pkg;

	localparam int CRC_W  = 10;
	localparam int DATA_W = 8;
	localparam int IDX_W  = 3;

	// Width select codes (code 3 behaves as 10 bits)
	localparam logic [1:0] WSEL_5  = 2'd0;
	localparam logic [1:0] WSEL_8  = 2'd1;
	localparam logic [1:0] WSEL_10 = 2'd2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH_SELECT = 3'd0;
	localparam logic [IDX_W-1:0] REG_POLYNOMIAL   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SEED_VALUE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_LSB_FIRST    = 3'd3;
	localparam logic [IDX_W-1:0] REG_REFLECT_CRC  = 3'd4;

	// Width masks
	localparam logic [CRC_W-1:0] MASK_5  = 10'h01F;
	localparam logic [CRC_W-1:0] MASK_8  = 10'h0FF;
	localparam logic [CRC_W-1:0] MASK_10 = 10'h3FF;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [1:0]       width_select;
		logic [CRC_W-1:0] polynomial;
		logic [CRC_W-1:0] seed_value;
		logic             lsb_first;
		logic             reflect_crc;
	} cfg_t;

	function automatic logic [CRC_W-1:0] width_mask(input logic [1:0] wsel);
		case (wsel)
			WSEL_5:  return MASK_5;
			WSEL_8:  return MASK_8;
			default: return MASK_10;
		endcase
	endfunction

	function automatic logic [3:0] width_bits(input logic [1:0] wsel);
		case (wsel)
			WSEL_5:  return 4'd5;
			WSEL_8:  return 4'd8;
			default: return 4'd10;
		endcase
	endfunction

	function automatic logic top_bit(input logic [CRC_W-1:0] r, input logic [1:0] wsel);
		case (wsel)
			WSEL_5:  return r[4];
			WSEL_8:  return r[7];
			default: return r[9];
		endcase
	endfunction

	// One shift of the register with feedback from the top bit of the width
	function automatic logic [CRC_W-1:0] shift_bit(input logic [CRC_W-1:0] r,
			input logic b, input logic [1:0] wsel, input logic [CRC_W-1:0] poly);
		logic [CRC_W-1:0] m;
		logic [CRC_W-1:0] nxt;
		m   = width_mask(wsel);
		nxt = {r[CRC_W-2:0], b} & m;
		if (top_bit(r, wsel)) begin
			nxt = nxt ^ (poly & m);
		end
		return nxt;
	endfunction

	// Bit-reverse the low width bits of a value already masked to the width
	function automatic logic [CRC_W-1:0] reverse_bits(input logic [CRC_W-1:0] v,
			input logic [1:0] wsel);
		logic [CRC_W-1:0] r10;
		for (int i = 0; i < CRC_W; i++) begin
			r10[i] = v[CRC_W-1-i];
		end
		case (wsel)
			WSEL_5:  return r10 >> 5;
			WSEL_8:  return r10 >> 2;
			default: return r10;
		endcase
	endfunction

endpackage

FILE: src/crcbam_byte_update.sv
// ----------------------------------------------------------------------------
// crcbam_byte_update
// Start value selection and eight unrolled shift steps for one data byte.
// ----------------------------------------------------------------------------
module crcbam_byte_update (
	input  crcbam_pkg::cfg_t                   cfg,
	input  logic                               first_byte,
	input  logic [crcbam_pkg::CRC_W-1:0]       crc_in,
	input  logic [crcbam_pkg::DATA_W-1:0]      data_byte,
	output logic [crcbam_pkg::CRC_W-1:0]       crc_out
);

	logic [crcbam_pkg::CRC_W-1:0] mask;
	logic [crcbam_pkg::CRC_W-1:0] start;

	// Seed (reflected if reflect_crc is set) on the first byte, else the running register
	always_comb begin
		mask = crcbam_pkg::width_mask(cfg.width_select);
		if (first_byte) begin
			start = cfg.seed_value & mask;
			if (cfg.reflect_crc) begin
				start = crcbam_pkg::reverse_bits(start, cfg.width_select);
			end
		end else begin
			start = crc_in & mask;
		end
	end

	// Eight data bits, MSB or LSB first
	always_comb begin
		logic [crcbam_pkg::CRC_W-1:0] r;
		logic [2:0]                   idx;
		r = start;
		for (int i = 0; i < crcbam_pkg::DATA_W; i++) begin
			idx = cfg.lsb_first ? i[2:0] : 3'(crcbam_pkg::DATA_W - 1 - i);
			r = crcbam_pkg::shift_bit(r, data_byte[idx], cfg.width_select,
				cfg.polynomial);
		end
		crc_out = r;
	end

endmodule

FILE: src/crcbam_finish.sv
// ----------------------------------------------------------------------------
// crcbam_finish
// Augmentation with width zero bits, optional reflection and final mask.
// ----------------------------------------------------------------------------
module crcbam_finish (
	input  crcbam_pkg::cfg_t             cfg,
	input  logic [crcbam_pkg::CRC_W-1:0] crc_in,
	output logic [crcbam_pkg::CRC_W-1:0] crc_value
);

	logic [3:0] aug_len;

	always_comb begin
		logic [crcbam_pkg::CRC_W-1:0] r;
		aug_len = crcbam_pkg::width_bits(cfg.width_select);
		r = crc_in;
		// Zero-bit shifts, only as many as the width
		for (int i = 0; i < crcbam_pkg::CRC_W; i++) begin
			if (4'(i) < aug_len) begin
				r = crcbam_pkg::shift_bit(r, 1'b0, cfg.width_select, cfg.polynomial);
			end
		end
		if (cfg.reflect_crc) begin
			r = crcbam_pkg::reverse_bits(r, cfg.width_select);
		end
		crc_value = r & crcbam_pkg::width_mask(cfg.width_select);
	end

endmodule

FILE: src/crc_bitwise_augmented_multi_width_top.sv
// ----------------------------------------------------------------------------
// crc_bitwise_augmented_multi_width_top
// Streaming 5/8/10-bit augmented CRC, one message byte per request.
// ----------------------------------------------------------------------------
// The block takes bytes on the slave stream and returns each message's CRC
// on the master stream, one request per message, after the input, stage 2
// and output registers. The byte stage is an unrolled eight-step shift/XOR
// network looping on the running CRC register, so a new byte can follow
// every unstalled cycle. Augmentation by width zero bits, the final
// reflection and masking sit in a separate stage after it. The whole
// pipeline stalls only while a finished CRC waits on m_tready. Configuration
// writes must be made with no message in progress and no result pending.
`include "assert_macros.svh"

module crc_bitwise_augmented_multi_width_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [crcbam_pkg::IDX_W-1:0] cfg_index,
	input  logic [crcbam_pkg::CRC_W-1:0] cfg_data,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic        s_tlast,    // last_byte
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata     // [9:0] crc_value, [15:10] zero
);

	crcbam_pkg::cfg_t cfg;

	logic [1:0]                      width_select_q;
	logic [crcbam_pkg::CRC_W-1:0]    polynomial_q;
	logic [crcbam_pkg::CRC_W-1:0]    seed_value_q;
	logic                            lsb_first_q;
	logic                            reflect_crc_q;

	logic                            advance;
	logic                            valid_s1;
	logic [crcbam_pkg::DATA_W-1:0]   data_s1;
	logic                            last_s1;
	logic [crcbam_pkg::CRC_W-1:0]    crc_q;
	logic                            in_msg_q;
	logic [crcbam_pkg::CRC_W-1:0]    byte_crc;
	logic                            valid_s2;
	logic [crcbam_pkg::CRC_W-1:0]    aug_s2;
	logic [crcbam_pkg::CRC_W-1:0]    fin_crc;
	logic                            valid_s3;
	logic [crcbam_pkg::CRC_W-1:0]    crc_s3;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_select_q <= crcbam_pkg::WSEL_8;
			polynomial_q   <= 10'd7;
			seed_value_q   <= '0;
			lsb_first_q    <= 1'b0;
			reflect_crc_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				crcbam_pkg::REG_WIDTH_SELECT: width_select_q <= cfg_data[1:0];
				crcbam_pkg::REG_POLYNOMIAL:   polynomial_q   <= cfg_data;
				crcbam_pkg::REG_SEED_VALUE:   seed_value_q   <= cfg_data;
				crcbam_pkg::REG_LSB_FIRST:    lsb_first_q    <= cfg_data[0];
				crcbam_pkg::REG_REFLECT_CRC:  reflect_crc_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = '{
		width_select: width_select_q,
		polynomial:   polynomial_q,
		seed_value:   seed_value_q,
		lsb_first:    lsb_first_q,
		reflect_crc:  reflect_crc_q
	};

	// Pipeline moves whenever the output register is free or being taken
	assign advance  = !valid_s3 || m_tready;
	assign s_tready = advance;

	// Stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Byte update network
	crcbam_byte_update u_byte (
		.cfg        (cfg),
		.first_byte (!in_msg_q),
		.crc_in     (crc_q),
		.data_byte  (data_s1),
		.crc_out    (byte_crc)
	);

	// Running CRC and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			in_msg_q <= 1'b0;
		end else if (advance && valid_s1) begin
			crc_q    <= byte_crc;
			in_msg_q <= !last_s1;
		end
	end

	// Stage 2: register holding a message's pre-augmentation CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && last_s1) begin
			aug_s2 <= byte_crc;
		end
	end

	// Augment, reflect, mask
	crcbam_finish u_finish (
		.cfg       (cfg),
		.crc_in    (aug_s2),
		.crc_value (fin_crc)
	);

	// Stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			crc_s3 <= fin_crc;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {6'd0, crc_s3};

	// Checks
	`ASSERT_SAME(a_crc5_masked, m_tvalid && (width_select_q == crcbam_pkg::WSEL_5),
		m_tdata[9:5] == 5'd0, "5-bit CRC has bits above its width")
	`ASSERT_SAME(a_crc8_masked, m_tvalid && (width_select_q == crcbam_pkg::WSEL_8),
		m_tdata[9:8] == 2'd0, "8-bit CRC has bits above its width")
	`ASSERT_NEXT(a_last_ends_msg, advance && valid_s1 && last_s1,
		!in_msg_q && valid_s2, "last byte did not close the message")
	`ASSERT_NEXT(a_result_follows, advance && valid_s2,
		m_tvalid, "finished CRC was not presented")

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming multi-width augmented CRC.
// ----------------------------------------------------------------------------
// Messages are fed one byte per request on the slave stream. A behavioral
// shift-register CRC predicts each finished value on the last byte and queues
// it or a typed table value. Results from the master stream are popped and
// compared in order. A short directed table walks the width codes, polynomial
// and seed extremes, bit order and reflection, and single-byte messages. Random
// phases follow, each with a fresh register setting written while the block is
// idle. Both streams get random gaps and stalls, with some calm stretches.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ITEMS        = 550;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT   = 2000;

	typedef enum bit {ROW_CFG, ROW_BYTE} row_kind_t;

	// One directed step: a register write or a message byte
	typedef struct {
		row_kind_t                    kind;
		logic [crcbam_pkg::IDX_W-1:0] idx;
		logic [crcbam_pkg::CRC_W-1:0] value;
		logic [7:0]                   data;
		logic                         last;
		bit                           typed;
		logic [crcbam_pkg::CRC_W-1:0] crc;
	} row_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [crcbam_pkg::IDX_W-1:0]  cfg_index = '0;
	logic [crcbam_pkg::CRC_W-1:0]  cfg_data  = '0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata   = '0;
	logic                          s_tlast   = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [15:0]                   m_tdata;

	// Predictor copy of the registers and the running CRC
	logic [1:0]                    p_wsel = crcbam_pkg::WSEL_8;
	logic [crcbam_pkg::CRC_W-1:0]  p_poly = 10'd7;
	logic [crcbam_pkg::CRC_W-1:0]  p_seed = '0;
	logic                          p_lsb  = 1'b0;
	logic                          p_refl = 1'b0;
	logic [crcbam_pkg::CRC_W-1:0]  p_crc  = '0;
	logic                          p_busy = 1'b0;

	logic [crcbam_pkg::CRC_W-1:0]  crc_expected[$];
	row_t                          dir_rows[$];

	int err_cnt   = 0;
	int n_bytes   = 0;
	int n_msgs    = 0;
	int n_writes  = 0;
	int n_checked = 0;
	int idle_cnt  = 0;
	int stall_left = 0;
	int calm_cnt  = 0;
	bit calm      = 1'b0;
	bit [3:0] wsel_seen = '0;

	crc_bitwise_augmented_multi_width_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	// Gap length: mostly none or short, a few long; none in calm stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Reverse the low n bits
	function automatic logic [crcbam_pkg::CRC_W-1:0] mirror(
			input logic [crcbam_pkg::CRC_W-1:0] v, input int n);
		logic [crcbam_pkg::CRC_W-1:0] r;
		r = '0;
		for (int i = 0; i < n; i++)
			r[n-1-i] = v[i];
		return r;
	endfunction

	// One register shift with feedback from bit n-1
	function automatic logic [crcbam_pkg::CRC_W-1:0] shift1(
			input logic [crcbam_pkg::CRC_W-1:0] r, input logic b, input int n,
			input logic [crcbam_pkg::CRC_W-1:0] msk, input logic [crcbam_pkg::CRC_W-1:0] fb);
		logic top;
		top = r[n-1];
		r = ((r << 1) | {{(crcbam_pkg::CRC_W-1){1'b0}}, b}) & msk;
		return top ? (r ^ fb) : r;
	endfunction

	// Fold one accepted byte into the predicted CRC
	task automatic advance_crc(input logic [7:0] d, input logic l,
			output logic [crcbam_pkg::CRC_W-1:0] crc);
		int n;
		int m;
		logic [crcbam_pkg::CRC_W-1:0] msk;
		logic [crcbam_pkg::CRC_W-1:0] fb;
		logic [crcbam_pkg::CRC_W-1:0] r;
		n = (p_wsel == crcbam_pkg::WSEL_5) ? 5 : (p_wsel == crcbam_pkg::WSEL_8) ? 8 : 10;
		m = (1 << n) - 1;
		msk = m[crcbam_pkg::CRC_W-1:0];
		fb = p_poly & msk;
		if (p_busy)
			r = p_crc & msk;
		else
			r = p_refl ? mirror(p_seed & msk, n) : (p_seed & msk);
		for (int i = 0; i < 8; i++)
			r = shift1(r, p_lsb ? d[i] : d[7-i], n, msk, fb);
		if (l) begin
			// augmentation by width zero bits
			for (int i = 0; i < n; i++)
				r = shift1(r, 1'b0, n, msk, fb);
			if (p_refl)
				r = mirror(r, n);
			r = r & msk;
		end
		p_crc  = r;
		p_busy = !l;
		crc    = r;
	endtask

	// Random register value, extremes weighted up
	function automatic logic [crcbam_pkg::CRC_W-1:0] rand_reg(
			input logic [crcbam_pkg::IDX_W-1:0] idx);
		int r;
		case (idx)
			crcbam_pkg::REG_WIDTH_SELECT: return 10'($urandom_range(0, 3));
			crcbam_pkg::REG_POLYNOMIAL, crcbam_pkg::REG_SEED_VALUE: begin
				r = $urandom_range(0, 7);
				if (r == 0)
					return '0;
				if (r == 1)
					return 10'h3FF;
				return 10'($urandom_range(0, 1023));
			end
			default: return 10'($urandom_range(0, 1));
		endcase
	endfunction

	// Register write request; valid stays high for back-to-back writes
	task automatic write_reg(input logic [crcbam_pkg::IDX_W-1:0] idx,
			input logic [crcbam_pkg::CRC_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		case (idx)
			crcbam_pkg::REG_WIDTH_SELECT: p_wsel = val[1:0];
			crcbam_pkg::REG_POLYNOMIAL:   p_poly = val;
			crcbam_pkg::REG_SEED_VALUE:   p_seed = val;
			crcbam_pkg::REG_LSB_FIRST:    p_lsb  = val[0];
			crcbam_pkg::REG_REFLECT_CRC:  p_refl = val[0];
			default: ;
		endcase
		n_writes++;
	endtask

	// Byte request with a random gap ahead of it
	task automatic send_byte(input logic [7:0] d, input logic l, input bit typed,
			input logic [crcbam_pkg::CRC_W-1:0] tcrc);
		int gap;
		logic [crcbam_pkg::CRC_W-1:0] crc;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= l;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		wsel_seen[p_wsel] = 1'b1;
		advance_crc(d, l, crc);
		if (l) begin
			crc_expected.push_back(typed ? tcrc : crc);
			n_msgs++;
		end
		n_bytes++;
	endtask

	// Hold the sender until every queued CRC has come out
	task automatic wait_results();
		s_tvalid <= 1'b0;
		while (crc_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic drain_idle();
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side stalls
	always @(posedge clk) begin
		calm_cnt++;
		if (calm_cnt == 300) begin
			calm_cnt = 0;
			calm = ($urandom_range(0, 3) == 0);
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result check; values are stable from the falling edge to the accepting edge
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (crc_expected.size() == 0) begin
				$display("%0t: unexpected CRC result 0x%04h", $time, m_tdata);
				err_cnt++;
			end else begin
				if (m_tdata !== {6'b0, crc_expected[0]}) begin
					$display("%0t: CRC mismatch, expected 0x%04h, actual 0x%04h", $time,
						{6'b0, crc_expected[0]}, m_tdata);
					err_cnt++;
				end
				void'(crc_expected.pop_front());
				n_checked++;
			end
		end
	end

	// Watchdog on cycles without any accepted request
	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt > IDLE_LIMIT) begin
			$display("%0t: timeout, %0d CRC results outstanding", $time, crc_expected.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus
	initial begin
		logic [crcbam_pkg::IDX_W-1:0] regs[5];
		int nw;
		int nm;
		int len;
		int r;
		logic [7:0] d;

		regs = '{crcbam_pkg::REG_WIDTH_SELECT, crcbam_pkg::REG_POLYNOMIAL,
			crcbam_pkg::REG_SEED_VALUE, crcbam_pkg::REG_LSB_FIRST,
			crcbam_pkg::REG_REFLECT_CRC};
		dir_rows = '{
			// reset setting: zero byte gives zero, CRC-8 of 0x01 is the polynomial
			'{ROW_BYTE, '0, '0, 8'h00, 1'b1, 1'b1, 10'h000},
			'{ROW_BYTE, '0, '0, 8'h01, 1'b1, 1'b1, 10'h007},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
			'{ROW_BYTE, '0, '0, 8'h80, 1'b1, 1'b0, '0},
			// 5-bit, polynomial and seed wider than the width
			'{ROW_CFG, crcbam_pkg::REG_WIDTH_SELECT, {8'b0, crcbam_pkg::WSEL_5}, '0,
				1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_POLYNOMIAL, 10'h3FF, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_SEED_VALUE, 10'h3FF, '0, 1'b0, 1'b0, '0},
			'{ROW_BYTE, '0, '0, 8'hA5, 1'b1, 1'b0, '0},
			// LSB first with reflection
			'{ROW_CFG, crcbam_pkg::REG_LSB_FIRST, 10'd1, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_REFLECT_CRC, 10'd1, '0, 1'b0, 1'b0, '0},
			'{ROW_BYTE, '0, '0, 8'h3C, 1'b0, 1'b0, '0},
			'{ROW_BYTE, '0, '0, 8'hC3, 1'b1, 1'b0, '0},
			// unused width code runs 10-bit; zero polynomial shifts everything out
			'{ROW_CFG, crcbam_pkg::REG_WIDTH_SELECT, 10'd3, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_POLYNOMIAL, 10'h000, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_SEED_VALUE, 10'h000, '0, 1'b0, 1'b0, '0},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 10'h000},
			// full 10-bit polynomial, MSB first, no reflection
			'{ROW_CFG, crcbam_pkg::REG_WIDTH_SELECT, {8'b0, crcbam_pkg::WSEL_10}, '0,
				1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_POLYNOMIAL, 10'h3FF, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_SEED_VALUE, 10'h2AA, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_LSB_FIRST, 10'd0, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_REFLECT_CRC, 10'd0, '0, 1'b0, 1'b0, '0},
			'{ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b0, '0},
			'{ROW_BYTE, '0, '0, 8'h55, 1'b0, 1'b0, '0},
			'{ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b0, '0},
			// 8-bit with all-ones seed, reflected
			'{ROW_CFG, crcbam_pkg::REG_WIDTH_SELECT, {8'b0, crcbam_pkg::WSEL_8}, '0,
				1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_POLYNOMIAL, 10'h01D, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_SEED_VALUE, 10'h0FF, '0, 1'b0, 1'b0, '0},
			'{ROW_CFG, crcbam_pkg::REG_REFLECT_CRC, 10'd1, '0, 1'b0, 1'b0, '0},
			'{ROW_BYTE, '0, '0, 8'h12, 1'b0, 1'b0, '0},
			'{ROW_BYTE, '0, '0, 8'h34, 1'b0, 1'b0, '0},
			'{ROW_BYTE, '0, '0, 8'h56, 1'b1, 1'b0, '0}
		};

		// reset
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk
		for (int i = 0; i < dir_rows.size(); i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				if (i == 0 || dir_rows[i-1].kind != ROW_CFG)
					drain_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].value);
				if (i + 1 >= dir_rows.size() || dir_rows[i+1].kind != ROW_CFG)
					cfg_valid <= 1'b0;
			end else begin
				send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
					dir_rows[i].crc);
			end
		end

		// random phases: new setting, then a batch of complete messages
		while (n_bytes < ITEMS) begin
			drain_idle();
			nw = 0;
			for (int k = 0; k < 5; k++) begin
				if ($urandom_range(0, 1) == 1 || (k == 4 && nw == 0)) begin
					write_reg(regs[k], rand_reg(regs[k]));
					nw++;
				end
			end
			cfg_valid <= 1'b0;
			nm = $urandom_range(2, 8);
			for (int j = 0; j < nm; j++) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(1, 4);
				else if (r < 95)
					len = $urandom_range(5, 12);
				else
					len = $urandom_range(13, 40);
				for (int b = 0; b < len; b++) begin
					r = $urandom_range(0, 9);
					d = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
					send_byte(d, b == len - 1, 1'b0, '0);
				end
				if ($urandom_range(0, 15) == 0)
					wait_results();
			end
		end

		// drain and report
		drain_idle();
		if (crc_expected.size() != 0) begin
			$display("%0t: %0d CRC results never arrived", $time, crc_expected.size());
			err_cnt++;
		end
		$display("Sent %0d bytes in %0d messages, checked %0d CRCs, %0d register writes",
			n_bytes, n_msgs, n_checked, n_writes);
		$display("Width codes exercised (bit per code 0..3): %b, errors: %0d",
			wsel_seen, err_cnt);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/crcbam_pkg.sv
src/crcbam_byte_update.sv
src/crcbam_finish.sv
src/crc_bitwise_augmented_multi_width_top.sv
verif/tb_top.sv
